// File: src/gba_pkg.sv
// Shared types, constants and defaults for the grouped bitmap allocator.
package gba_pkg;

	localparam int NUM_W       = 13;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_W       = 13;
	localparam int WORD_MAX    = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam int GROUP_BITS_DEF  = 1024;
	localparam int GROUP_COUNT_DEF = 4;

	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_VALID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT  = 2'd2;

	typedef enum logic [1:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_MARK,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [NUM_W-1:0] number;
		logic [NUM_W-1:0] pos;
	} cmd_t;

	typedef struct packed {
		logic             number_base;
		logic [NUM_W-1:0] first_valid;
		logic [NUM_W-1:0] limit;
	} cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_GROUP,
		BK_READ,
		BK_CHECK
	} bk_state_t;

endpackage

// File: src/gba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/gba_front.sv
// Front end: takes requests, range-checks them and queues commands for the engine.
module gba_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [gba_pkg::MODE_W-1:0] mode,
	input  logic [gba_pkg::NUM_W-1:0]  item_number,
	input  gba_pkg::cfg_t            cfg,
	input  logic                     cmd_take,
	output logic                     cmd_valid,
	output gba_pkg::cmd_t            cmd
);
	import gba_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            q_q [QUEUE_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [CNTW-1:0] cnt_q;
	cmd_t            cls;
	logic [NUM_W-1:0] pos;
	logic            wr, rd;

	// classify: everything that can be decided without the bitmap
	always_comb begin
		pos        = item_number - NUM_W'(cfg.number_base);
		cls.number = item_number;
		cls.pos    = pos;
		cls.kind   = CMD_REJECT;
		case (mode)
			MODE_ALLOC: cls.kind = CMD_ALLOC;
			MODE_FREE: begin
				if (item_number >= NUM_W'(cfg.number_base) && pos < cfg.limit &&
				    item_number >= cfg.first_valid) begin
					cls.kind = CMD_FREE;
				end
			end
			MODE_MARK: begin
				if (item_number >= NUM_W'(cfg.number_base) && pos < cfg.limit) begin
					cls.kind = CMD_MARK;
				end
			end
			default: cls.kind = CMD_REJECT;
		endcase
	end

	assign full      = (cnt_q == CNTW'(QUEUE_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rp_q];
	assign wr        = push && !full;
	assign rd        = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/gba_back.sv
// Back end: bitmap RAM, group counters, first-fit search and result register.
module gba_back #(
	parameter int GROUP_BITS  = gba_pkg::GROUP_BITS_DEF,
	parameter int GROUP_COUNT = gba_pkg::GROUP_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gba_pkg::cfg_t               cfg,
	input  logic                        cmd_valid,
	input  gba_pkg::cmd_t               cmd,
	output logic                        cmd_take,
	input  logic                        pop,
	output logic                        empty,
	output logic [gba_pkg::NUM_W-1:0]    result_number,
	output logic [gba_pkg::STATUS_W-1:0] status
);
	import gba_pkg::*;

	localparam int MAP    = GROUP_BITS * GROUP_COUNT;
	localparam int WORD_W = (GROUP_BITS < WORD_MAX) ? GROUP_BITS : WORD_MAX;
	localparam int WB     = $clog2(WORD_W);
	localparam int WORDS  = MAP / WORD_W;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int WPG    = GROUP_BITS / WORD_W;
	localparam int GB     = $clog2(GROUP_BITS);
	localparam int GW     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int GCW    = $clog2(GROUP_COUNT + 1);
	localparam int CW     = $clog2(GROUP_BITS + 1);
	localparam int SW     = $clog2(MAP) + 1;
	localparam int XW     = (SW > NUM_W + 1) ? SW : NUM_W + 1;

	bk_state_t          state_q, state_d;
	cmd_t               cmd_q;
	logic [GCW-1:0]     g_q;
	logic [AW-1:0]      addr_q;
	logic [CW-1:0]      cnt_q [GROUP_COUNT];
	logic [WORDS-1:0]   wval_q;
	logic               out_valid_q;
	logic [NUM_W-1:0]   out_num_q;
	logic [STATUS_W-1:0] out_stat_q;

	logic [WORD_W-1:0]  rdata, word, lim_mask, free_bits, onehot, wdata;
	logic [WB-1:0]      free_idx, bit_idx;
	logic               any_free, last_in_grp, grp_end, grp_full, word_out;
	logic [XW-1:0]      gbase, wbase, avail, limit_x;
	logic [GW-1:0]      g_idx, pos_grp;

	// datapath controls
	logic               ram_re, ram_we;
	logic               cnt_dec, cnt_inc;
	logic [GW-1:0]      cnt_sel;
	logic               out_load;
	logic [NUM_W-1:0]   out_num;
	logic [STATUS_W-1:0] out_stat;

	gba_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign limit_x     = XW'(cfg.limit);
	assign g_idx       = g_q[GW-1:0];
	assign gbase       = XW'(g_q) << GB;
	assign wbase       = XW'(addr_q) << WB;
	assign avail       = limit_x - wbase;
	assign grp_end     = (g_q == GCW'(GROUP_COUNT)) || (gbase >= limit_x);
	assign grp_full    = (cnt_q[g_idx] == '0);
	assign word_out    = (wbase >= limit_x);
	assign last_in_grp = ((addr_q & AW'(WPG - 1)) == AW'(WPG - 1));
	assign word        = wval_q[addr_q] ? rdata : '0;
	assign bit_idx     = cmd_q.pos[WB-1:0];
	assign pos_grp     = GW'(cmd_q.pos >> GB);

	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			lim_mask[i] = (XW'(i) < avail);
		end
	end

	assign free_bits = ~word & lim_mask;
	assign any_free  = (free_bits != '0);

	always_comb begin
		free_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				free_idx = WB'(i);
			end
		end
	end

	always_comb begin
		onehot = '0;
		if (cmd_q.kind == CMD_ALLOC) begin
			onehot[free_idx] = 1'b1;
		end else begin
			onehot[bit_idx] = 1'b1;
		end
	end

	assign wdata = (cmd_q.kind == CMD_FREE) ? (word & ~onehot) : (word | onehot);

	assign cmd_take = (state_q == BK_IDLE) && cmd_valid && !out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_take) begin
					case (cmd.kind)
						CMD_ALLOC:  state_d = BK_GROUP;
						CMD_REJECT: state_d = BK_IDLE;
						default:    state_d = BK_READ;
					endcase
				end
			end
			BK_GROUP: begin
				if (grp_end) begin
					state_d = BK_IDLE;
				end else if (!grp_full) begin
					state_d = BK_READ;
				end
			end
			BK_READ: state_d = BK_CHECK;
			BK_CHECK: begin
				if (cmd_q.kind != CMD_ALLOC || word_out || any_free) begin
					state_d = BK_IDLE;
				end else if (last_in_grp) begin
					state_d = BK_GROUP;
				end else begin
					state_d = BK_READ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// datapath actions
	always_comb begin
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		cnt_dec  = 1'b0;
		cnt_inc  = 1'b0;
		cnt_sel  = pos_grp;
		out_load = 1'b0;
		out_num  = cmd_q.number;
		out_stat = ST_OK;
		case (state_q)
			BK_IDLE: begin
				if (cmd_take && cmd.kind == CMD_REJECT) begin
					out_load = 1'b1;
					out_num  = cmd.number;
					out_stat = ST_RANGE;
				end
			end
			BK_GROUP: begin
				if (grp_end) begin
					out_load = 1'b1;
					out_num  = '0;
					out_stat = ST_NOSPACE;
				end
			end
			BK_READ: ram_re = 1'b1;
			BK_CHECK: begin
				case (cmd_q.kind)
					CMD_ALLOC: begin
						cnt_sel = g_idx;
						if (word_out) begin
							out_load = 1'b1;
							out_num  = '0;
							out_stat = ST_NOSPACE;
						end else if (any_free) begin
							ram_we   = 1'b1;
							cnt_dec  = 1'b1;
							out_load = 1'b1;
							out_num  = NUM_W'(wbase + XW'(free_idx) + XW'(cfg.number_base));
						end
					end
					CMD_FREE: begin
						out_load = 1'b1;
						if (!word[bit_idx]) begin
							out_stat = ST_ALREADY;
						end else begin
							ram_we  = 1'b1;
							cnt_inc = 1'b1;
						end
					end
					default: begin
						out_load = 1'b1;
						if (word[bit_idx]) begin
							out_stat = ST_ALREADY;
						end else begin
							ram_we  = 1'b1;
							cnt_dec = 1'b1;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (out_load) begin
			out_num_q  <= out_num;
			out_stat_q <= out_stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			g_q         <= '0;
			addr_q      <= '0;
			wval_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < GROUP_COUNT; i++) begin
				cnt_q[i] <= CW'(GROUP_BITS);
			end
		end else begin
			state_q <= state_d;
			if (cmd_take) begin
				g_q    <= '0;
				addr_q <= AW'(cmd.pos >> WB);
			end else if (state_q == BK_GROUP && !grp_end) begin
				if (grp_full) begin
					g_q <= g_q + 1'b1;
				end else begin
					addr_q <= AW'(XW'(g_q) << (GB - WB));
				end
			end else if (state_q == BK_CHECK && cmd_q.kind == CMD_ALLOC &&
			             !word_out && !any_free) begin
				if (last_in_grp) begin
					g_q <= g_q + 1'b1;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			if (ram_we) begin
				wval_q[addr_q] <= 1'b1;
			end
			if (cnt_dec && cnt_q[cnt_sel] != '0) begin
				cnt_q[cnt_sel] <= cnt_q[cnt_sel] - 1'b1;
			end else if (cnt_inc && cnt_q[cnt_sel] != CW'(GROUP_BITS)) begin
				cnt_q[cnt_sel] <= cnt_q[cnt_sel] + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty         = !out_valid_q;
	assign result_number = out_num_q;
	assign status        = out_stat_q;

endmodule

// File: src/grouped_bitmap_allocator.sv
// Top level of the grouped first-fit bitmap allocator.
//
// Requests enter through a queue-style port: mode and item_number are
// transferred on a clock edge with push high and full low. Results leave the
// same way: while empty is low, result_number and status hold the oldest
// result, and it is transferred on an edge with pop high.
// Configuration registers (number_base, first_valid, item_count) are written
// through cfg_we / cfg_index / cfg_wdata; the user writes them only while the
// block is idle, and the block itself does not enforce this.
// A two-entry command queue sits between the range-checking front end and
// the engine, so requests keep flowing in while a result waits to be popped.
// A rejected request is answered straight from the command queue; free and
// mark pass through queue hand-over, bitmap RAM read and update.
// Allocation walks the group counters one group per cycle and then the bitmap
// words of the first group with free bits, each word read and then checked,
// moving on to the next group when a group's words hold no clear bit.
// If pop is held low the result stays put, the engine stalls behind it and
// full rises once the queue holds two commands.
// Reset clears the map (through per-word valid bits, no clearing pass),
// sets every group counter to the group size and empties both queues.
module grouped_bitmap_allocator #(
	parameter int GROUP_BITS  = gba_pkg::GROUP_BITS_DEF,
	parameter int GROUP_COUNT = gba_pkg::GROUP_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [gba_pkg::MODE_W-1:0]    mode,
	input  logic [gba_pkg::NUM_W-1:0]     item_number,
	input  logic                          pop,
	output logic                          empty,
	output logic [gba_pkg::NUM_W-1:0]     result_number,
	output logic [gba_pkg::STATUS_W-1:0]  status,
	input  logic                          cfg_we,
	input  logic [gba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gba_pkg::CFG_W-1:0]     cfg_wdata
);
	import gba_pkg::*;

	// map size clipped to what a number can reach
	localparam int MAP = GROUP_BITS * GROUP_COUNT;
	localparam logic [NUM_W-1:0] MAP_CAP = NUM_W'((MAP > 8191) ? 8191 : MAP);

	logic             number_base_q;
	logic [NUM_W-1:0] first_valid_q;
	logic [NUM_W-1:0] item_count_q;
	cfg_t             cfg;
	cmd_t             cmd;
	logic             cmd_valid, cmd_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= 1'b0;
			first_valid_q <= '0;
			item_count_q  <= NUM_W'(4096);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUMBER_BASE: number_base_q <= cfg_wdata[0];
				REG_FIRST_VALID: first_valid_q <= cfg_wdata;
				REG_ITEM_COUNT:  item_count_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// item_count beyond the map acts as the map size
	assign cfg.number_base = number_base_q;
	assign cfg.first_valid = first_valid_q;
	assign cfg.limit       = (item_count_q > MAP_CAP) ? MAP_CAP : item_count_q;

	gba_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.item_number (item_number),
		.cfg         (cfg),
		.cmd_take    (cmd_take),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd)
	);

	gba_back #(
		.GROUP_BITS  (GROUP_BITS),
		.GROUP_COUNT (GROUP_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_take      (cmd_take),
		.pop           (pop),
		.empty         (empty),
		.result_number (result_number),
		.status        (status)
	);

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the grouped first-fit bitmap allocator.
`timescale 1ns / 1ps

module testbench;
	import gba_pkg::*;

	localparam int MAP_SIZE   = GROUP_BITS_DEF * GROUP_COUNT_DEF;
	localparam int N_PHASES   = 6;
	localparam int RAND_ITEMS = 125;
	localparam int DRAIN_WAIT = 120;   // idle gap before the registers change
	localparam int STALL_MAX  = 5000;  // cycles without any transfer

	typedef struct {
		logic [MODE_W-1:0] op;
		logic [NUM_W-1:0]  num;
	} request_t;

	typedef struct {
		logic [NUM_W-1:0]    num;
		logic [STATUS_W-1:0] st;
	} outcome_t;

	logic                 clk, arst_n;
	logic                 push, full, pop, empty;
	logic [MODE_W-1:0]    mode;
	logic [NUM_W-1:0]     item_number, result_number;
	logic [STATUS_W-1:0]  status;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	grouped_bitmap_allocator dut (.*);

	// shadow of the allocator state and registers
	logic        map_used [MAP_SIZE];
	int unsigned grp_free [GROUP_COUNT_DEF];
	logic        sh_base;
	logic [12:0] sh_first, sh_count;

	request_t requests_pending[$];
	outcome_t outcomes_due[$];
	int       mismatches;
	bit       calm_phase;   // no idling on either side
	bit       hold_armed;   // receiver to hold off for a long stretch

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input logic [NUM_W-1:0] got,
			input logic [NUM_W-1:0] want);
		$display("[%0t] %s: got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// first-fit allocation and free/mark bookkeeping, one call per transfer
	function automatic outcome_t allocator_outcome(input logic [MODE_W-1:0] op,
			input logic [NUM_W-1:0] num);
		outcome_t    o;
		int unsigned lim, p;
		bit          found;
		lim = (sh_count < MAP_SIZE) ? sh_count : MAP_SIZE;
		o.num = num;
		o.st  = ST_OK;
		found = 0;
		if (op == MODE_ALLOC) begin
			o.num = '0;
			o.st  = ST_NOSPACE;
			for (int g = 0; g < GROUP_COUNT_DEF && !found; g++) begin
				if (grp_free[g] == 0)
					continue;
				for (int b = 0; b < GROUP_BITS_DEF; b++) begin
					p = g * GROUP_BITS_DEF + b;
					if (p >= lim)
						break;
					if (!map_used[p]) begin
						map_used[p] = 1'b1;
						if (grp_free[g] > 0)
							grp_free[g]--;
						o.num = NUM_W'(p + sh_base);
						o.st  = ST_OK;
						found = 1;
						break;
					end
				end
			end
		end else if (op == MODE_FREE || op == MODE_MARK) begin
			if (num < sh_base) begin
				o.st = ST_RANGE;
			end else begin
				p = num - sh_base;
				if (p >= lim || (op == MODE_FREE && num < sh_first)) begin
					o.st = ST_RANGE;
				end else if (op == MODE_FREE) begin
					if (!map_used[p]) begin
						o.st = ST_ALREADY;
					end else begin
						map_used[p] = 1'b0;
						if (grp_free[p / GROUP_BITS_DEF] < GROUP_BITS_DEF)
							grp_free[p / GROUP_BITS_DEF]++;
					end
				end else begin
					if (map_used[p]) begin
						o.st = ST_ALREADY;
					end else begin
						map_used[p] = 1'b1;
						if (grp_free[p / GROUP_BITS_DEF] > 0)
							grp_free[p / GROUP_BITS_DEF]--;
					end
				end
			end
		end else begin
			o.st = ST_RANGE;   // unused mode
		end
		return o;
	endfunction

	task automatic add_request(input logic [MODE_W-1:0] op, input logic [NUM_W-1:0] num);
		request_t r;
		r.op  = op;
		r.num = num;
		requests_pending.push_back(r);
	endtask

	// Driver: a transfer happens at an edge with push high and full low.
	// Each item waits a randomly drawn gap unless the phase runs calm.
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		logic   push_nx;
		int     gap_nx;
		if (!arst_n) begin
			push        <= 1'b0;
			mode        <= MODE_ALLOC;
			item_number <= '0;
			gap_left    <= 0;
		end else begin
			gap_nx = gap_left;
			if (push && !full) begin
				outcomes_due.push_back(allocator_outcome(mode, item_number));
				void'(requests_pending.pop_front());
				gap_nx = calm_phase ? 0 : $urandom_range(0, 9);
			end
			push_nx = 1'b0;
			if (gap_nx > 0) begin
				gap_nx--;
			end else if (requests_pending.size() > 0) begin
				push_nx = 1'b1;
				mode        <= requests_pending[0].op;
				item_number <= requests_pending[0].num;
			end
			push     <= push_nx;
			gap_left <= gap_nx;
		end
	end

	// Monitor: compare each result transfer with the oldest outcome due.
	int  stall_left, hold_left;
	bit  hold_taken;
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		int       stall_nx;
		if (!arst_n) begin
			pop        <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
			hold_taken <= 1'b0;
		end else begin
			stall_nx = stall_left;
			if (pop && !empty) begin
				if (outcomes_due.size() == 0) begin
					report("result with nothing due", result_number, '0);
				end else begin
					want = outcomes_due.pop_front();
					if (result_number !== want.num)
						report("result_number", result_number, want.num);
					if (status !== want.st)
						report("status", NUM_W'(status), NUM_W'(want.st));
				end
				stall_nx = calm_phase ? 0 : $urandom_range(0, 9);
			end
			if (hold_armed && !hold_taken) begin
				// long hold-off so the block fills up and pushes back
				hold_taken <= 1'b1;
				hold_left  <= 150;
				pop        <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pop       <= 1'b0;
			end else if (stall_nx > 0) begin
				stall_nx--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
			stall_left <= stall_nx;
		end
	end

	// Watchdog: cycles with work outstanding but no transfer on either side
	int quiet_cycles;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)
				|| (requests_pending.size() == 0 && outcomes_due.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_NUMBER_BASE)
			sh_base = val[0];
		else if (idx == REG_FIRST_VALID)
			sh_first = val;
		else if (idx == REG_ITEM_COUNT)
			sh_count = val;
	endtask

	function automatic logic [NUM_W-1:0] pick_number();
		int unsigned k, lim;
		k = $urandom_range(0, 99);
		lim = sh_count;
		if (k < 60)
			return NUM_W'($urandom_range(0, 72));   // where allocations land
		else if (k < 75)
			return NUM_W'(lim + sh_base - 2 + $urandom_range(0, 3));   // around the limit
		else
			return NUM_W'($urandom_range(0, 8191));
	endfunction

	// register settings per phase: number_base, first_valid, item_count
	logic [12:0] ph_base  [N_PHASES] = '{0, 1,   0,    1,  0,    0};
	logic [12:0] ph_first [N_PHASES] = '{0, 5,   4096, 0,  8191, 30};
	logic [12:0] ph_count [N_PHASES] = '{4096, 40, 1,  8191, 0,  2000};

	initial begin
		int k;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_NUMBER_BASE;
		cfg_wdata   = '0;
		calm_phase  = 1'b0;
		hold_armed  = 1'b0;
		mismatches  = 0;
		sh_base     = 1'b0;
		sh_first    = '0;
		sh_count    = 13'd4096;
		for (int i = 0; i < MAP_SIZE; i++)
			map_used[i] = 1'b0;
		for (int g = 0; g < GROUP_COUNT_DEF; g++)
			grp_free[g] = GROUP_BITS_DEF;
		repeat (2) @(posedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// sender pauses until every outcome is in, then the engine settles
			wait (requests_pending.size() == 0 && outcomes_due.size() == 0);
			repeat (DRAIN_WAIT) @(posedge clk);
			write_reg(REG_NUMBER_BASE, ph_base[ph]);
			write_reg(REG_FIRST_VALID, ph_first[ph]);
			write_reg(REG_ITEM_COUNT, ph_count[ph]);
			@(posedge clk);
			cfg_we <= 1'b0;
			calm_phase = (ph == 2);
			if (ph == 0) begin
				// extremes, every mode, already-in-state and range cases
				add_request(MODE_ALLOC, 13'h1fff);
				add_request(MODE_ALLOC, 13'd0);
				add_request(MODE_FREE, 13'd0);
				add_request(MODE_FREE, 13'd0);
				add_request(MODE_MARK, 13'd5);
				add_request(MODE_MARK, 13'd5);
				add_request(MODE_MARK, 13'd4095);
				add_request(MODE_MARK, 13'd4096);
				add_request(MODE_FREE, 13'h1fff);
				add_request(2'd3, 13'h1fff);
				add_request(2'd3, 13'd0);
				add_request(MODE_FREE, 13'd4095);
				add_request(MODE_ALLOC, 13'd0);
			end else if (ph == 1) begin
				// number base, first_valid and an allocation limit of 40
				add_request(MODE_FREE, 13'd0);
				add_request(MODE_MARK, 13'd0);
				add_request(MODE_MARK, 13'd1);
				add_request(MODE_FREE, 13'd1);
				add_request(MODE_MARK, 13'd40);
				add_request(MODE_MARK, 13'd41);
				for (int i = 0; i < 6; i++)
					add_request(MODE_ALLOC, '0);
				hold_armed = 1'b1;
			end
			for (int i = 0; i < RAND_ITEMS; i++) begin
				k = $urandom_range(0, 99);
				if (k < 45)
					add_request(MODE_ALLOC, NUM_W'($urandom_range(0, 8191)));
				else if (k < 75)
					add_request(MODE_FREE, pick_number());
				else if (k < 95)
					add_request(MODE_MARK, pick_number());
				else
					add_request(2'd3, NUM_W'($urandom_range(0, 8191)));
			end
		end

		wait (requests_pending.size() == 0 && outcomes_due.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
